// File: rtl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

  typedef enum logic [1:0] {
    CASE_TWO_REAL = 2'd0,
    CASE_DOUBLE   = 2'd1,
    CASE_COMPLEX  = 2'd2,
    CASE_DEGEN    = 2'd3
  } root_case_t;

  localparam int FRAC_SHIFT = 16;
  localparam int ROOT_W     = 32;

  typedef struct packed {
    root_case_t        root_case;
    logic [ROOT_W-1:0] first_real;
    logic [ROOT_W-1:0] second_real;
    logic [ROOT_W-1:0] first_imag;
    logic              overflow;
  } result_t;

endpackage

// File: rtl/qrs_disc.sv
// Discriminant front end: magnitudes, products, then exact b*b-4ac and case code.
module qrs_disc #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] coef_quad,
  input  logic signed [W-1:0] coef_lin,
  input  logic signed [W-1:0] coef_const,
  output logic                out_valid,
  output qrs_pkg::root_case_t out_case,
  output logic [2*W:0]        dmag,
  output logic signed [W+16:0] neg_lin,
  output logic signed [W+1:0] two_quad
);

  logic [W-1:0] mag_a, mag_b, mag_c;
  logic [2*W-1:0] prod_ac;
  logic         v1;
  logic signed [W-1:0] a1, b1;
  logic [2*W-1:0] bsq1;
  logic [2*W+1:0] fac1;
  logic           addm1;

  logic [2*W+1:0] bsq_x, sum, dif_bf, dif_fb;
  logic           pos, zero;
  logic signed [W+16:0] bx;

  assign mag_a = coef_quad[W-1]  ? (~coef_quad + 1'b1)  : coef_quad;
  assign mag_b = coef_lin[W-1]   ? (~coef_lin + 1'b1)   : coef_lin;
  assign mag_c = coef_const[W-1] ? (~coef_const + 1'b1) : coef_const;
  assign prod_ac = mag_a * mag_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= coef_quad;
      b1    <= coef_lin;
      bsq1  <= mag_b * mag_b;
      fac1  <= {prod_ac, 2'b00};
      addm1 <= (coef_quad[W-1] != coef_const[W-1]) && (coef_const != '0);
    end
  end

  always_comb begin
    bsq_x  = {2'b00, bsq1};
    sum    = bsq_x + fac1;
    dif_bf = bsq_x - fac1;
    dif_fb = fac1 - bsq_x;
    pos    = addm1 || (bsq_x > fac1);
    zero   = !addm1 && (bsq_x == fac1);
    bx     = {{17{b1[W-1]}}, b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (addm1) begin
        dmag <= sum[2*W:0];
      end else if (pos) begin
        dmag <= dif_bf[2*W:0];
      end else begin
        dmag <= dif_fb[2*W:0];
      end
      if (a1 == '0) begin
        out_case <= qrs_pkg::CASE_DEGEN;
      end else if (pos) begin
        out_case <= qrs_pkg::CASE_TWO_REAL;
      end else if (zero) begin
        out_case <= qrs_pkg::CASE_DOUBLE;
      end else begin
        out_case <= qrs_pkg::CASE_COMPLEX;
      end
      neg_lin  <= -(bx <<< qrs_pkg::FRAC_SHIFT);
      two_quad <= {{1{a1[W-1]}}, a1, 1'b0};
    end
  end

endmodule

// File: rtl/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module qrs_sqrt #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] radicand,
  output logic [RW-1:0]   root
);

  logic [RW:0]     rem_s  [RW+1];
  logic [RW-1:0]   root_s [RW+1];
  logic [2*RW-1:0] rad_s  [RW+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = radicand;
  assign root      = root_s[RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [RW+2:0] cur, trial, diff;
    logic          ge;

    always_comb begin
      cur   = {rem_s[g], rad_s[g][2*RW-1 -: 2]};
      trial = {1'b0, root_s[g], 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1]  <= ge ? diff[RW:0] : cur[RW:0];
        root_s[g+1] <= {root_s[g][RW-2:0], ge};
        rad_s[g+1]  <= {rad_s[g][2*RW-3:0], 2'b00};
      end
    end
  end

endmodule

// File: rtl/qrs_div.sv
// Pipelined signed divider: round to nearest, one quotient bit per stage, saturate to 32 bits.
module qrs_div #(
  parameter int NW = 35,
  parameter int DW = 18
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic [qrs_pkg::ROOT_W-1:0] quo,
  output logic                 ovf
);

  localparam int OW = qrs_pkg::ROOT_W;

  logic [NW-1:0] un;
  logic [DW-1:0] ud;

  logic [DW-1:0] rem_s [NW+1];
  logic [NW-1:0] nq_s  [NW+1];
  logic [DW-1:0] den_s [NW+1];
  logic          neg_s [NW+1];

  logic [NW+OW:0] qx;
  localparam logic [NW+OW:0] POS_LIM = (NW+OW+1)'(64'h7FFF_FFFF);
  localparam logic [NW+OW:0] NEG_LIM = (NW+OW+1)'(64'h8000_0000);

  assign un = num[NW-1] ? (~num + 1'b1) : num;
  assign ud = den[DW-1] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= '0;
      nq_s[0]  <= un + NW'(ud >> 1);
      den_s[0] <= ud;
      neg_s[0] <= num[NW-1] != den[DW-1];
    end
  end

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [DW:0] cur, diff;
    logic        ge;

    always_comb begin
      cur  = {rem_s[g], nq_s[g][NW-1]};
      diff = cur - {1'b0, den_s[g]};
      ge   = (cur >= {1'b0, den_s[g]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        nq_s[g+1]  <= {nq_s[g][NW-2:0], ge};
        den_s[g+1] <= den_s[g];
        neg_s[g+1] <= neg_s[g];
      end
    end
  end

  assign qx = {{(OW+1){1'b0}}, nq_s[NW]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (!neg_s[NW] && qx > POS_LIM) begin
        quo <= 32'h7FFF_FFFF;
        ovf <= 1'b1;
      end else if (neg_s[NW] && qx > NEG_LIM) begin
        quo <= 32'h8000_0000;
        ovf <= 1'b1;
      end else begin
        quo <= neg_s[NW] ? (~qx[OW-1:0] + 1'b1) : qx[OW-1:0];
        ovf <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/quadratic_root_solver_top.sv
// Quadratic root solver top level: discriminant, square root, three dividers, output register.
// Pipeline from request to result:
//   2 discriminant stages, COEF_WIDTH+17 square-root stages, 1 numerator stage,
//   COEF_WIDTH+21 divider stages, 1 output register.
// Throughput: one request per cycle; the whole pipeline holds while a result is refused.
// Reset clears the valid bits only; data registers are not reset.
module quadratic_root_solver_top #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // coef_quad, coef_lin, coef_const
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // root_case, first_real, second_real, first_imag, overflow
  output logic [103:0]                     m_tdata
);

  localparam int W     = COEF_WIDTH;
  localparam int SW    = W + 17;
  localparam int NW    = W + 19;
  localparam int DW    = W + 2;
  localparam int DLAT  = NW + 3;

  typedef struct packed {
    logic                valid;
    qrs_pkg::root_case_t rcase;
    logic signed [W+16:0] nb;
    logic signed [DW-1:0] two_a;
  } sq_side_t;

  typedef struct packed {
    logic                valid;
    qrs_pkg::root_case_t rcase;
  } dv_side_t;

  logic en;
  logic d_valid;
  qrs_pkg::root_case_t d_case;
  logic [2*W:0] d_mag;
  logic signed [W+16:0] d_nb;
  logic signed [DW-1:0] d_two_a;
  logic [SW-1:0] sroot;

  sq_side_t sq_dl [SW];
  dv_side_t dv_dl [DLAT];

  logic signed [NW-1:0] n1, n2, n3;
  logic signed [DW-1:0] nden;
  logic [31:0] q1, q2, q3;
  logic o1, o2, o3;
  logic signed [NW-1:0] sx, nbx;
  dv_side_t dv_tail;

  qrs_pkg::result_t res;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  qrs_disc #(.W(W)) u_disc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .coef_quad (s_tdata[W-1:0]),
    .coef_lin  (s_tdata[2*W-1:W]),
    .coef_const(s_tdata[3*W-1:2*W]),
    .out_valid (d_valid),
    .out_case  (d_case),
    .dmag      (d_mag),
    .neg_lin   (d_nb),
    .two_quad  (d_two_a)
  );

  qrs_sqrt #(.RW(SW)) u_sqrt (
    .clk     (clk),
    .en      (en),
    .radicand({1'b0, d_mag, 32'h0}),
    .root    (sroot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SW; i++) begin
        sq_dl[i].valid <= 1'b0;
      end
    end else if (en) begin
      sq_dl[0] <= '{valid: d_valid, rcase: d_case, nb: d_nb, two_a: d_two_a};
      for (int i = 1; i < SW; i++) begin
        sq_dl[i] <= sq_dl[i-1];
      end
    end
  end

  assign sx  = {{(NW-SW){1'b0}}, sroot};
  assign nbx = {{(NW-W-17){sq_dl[SW-1].nb[W+16]}}, sq_dl[SW-1].nb};

  always_ff @(posedge clk) begin
    if (en) begin
      if (sq_dl[SW-1].rcase == qrs_pkg::CASE_TWO_REAL) begin
        n1 <= nbx + sx;
        n2 <= nbx - sx;
      end else begin
        n1 <= nbx;
        n2 <= nbx;
      end
      n3   <= sx;
      nden <= sq_dl[SW-1].two_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLAT; i++) begin
        dv_dl[i].valid <= 1'b0;
      end
    end else if (en) begin
      dv_dl[0] <= '{valid: sq_dl[SW-1].valid, rcase: sq_dl[SW-1].rcase};
      for (int i = 1; i < DLAT; i++) begin
        dv_dl[i] <= dv_dl[i-1];
      end
    end
  end

  qrs_div #(.NW(NW), .DW(DW)) u_div_first (
    .clk(clk), .en(en), .num(n1), .den(nden), .quo(q1), .ovf(o1)
  );

  qrs_div #(.NW(NW), .DW(DW)) u_div_second (
    .clk(clk), .en(en), .num(n2), .den(nden), .quo(q2), .ovf(o2)
  );

  qrs_div #(.NW(NW), .DW(DW)) u_div_imag (
    .clk(clk), .en(en), .num(n3), .den(nden), .quo(q3), .ovf(o3)
  );

  assign dv_tail = dv_dl[DLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.root_case <= dv_tail.rcase;
      case (dv_tail.rcase)
        qrs_pkg::CASE_TWO_REAL: begin
          res.first_real  <= q1;
          res.second_real <= q2;
          res.first_imag  <= '0;
          res.overflow    <= o1 | o2;
        end
        qrs_pkg::CASE_DOUBLE: begin
          res.first_real  <= q1;
          res.second_real <= q1;
          res.first_imag  <= '0;
          res.overflow    <= o1;
        end
        qrs_pkg::CASE_COMPLEX: begin
          res.first_real  <= q1;
          res.second_real <= q1;
          res.first_imag  <= q3;
          res.overflow    <= o1 | o3;
        end
        default: begin
          res.first_real  <= '0;
          res.second_real <= '0;
          res.first_imag  <= '0;
          res.overflow    <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = {5'b0, res.overflow, res.first_imag, res.second_real, res.first_real,
                    res.root_case};

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.root_case == qrs_pkg::CASE_DEGEN |->
      res.first_real == '0 && res.second_real == '0 && res.first_imag == '0 && !res.overflow)
    else $error("degenerate result carries nonzero roots");

  a_pair_real: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.root_case == qrs_pkg::CASE_DOUBLE ||
                 res.root_case == qrs_pkg::CASE_COMPLEX) |->
      res.first_real == res.second_real)
    else $error("double or complex result has differing real parts");

  a_real_no_imag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.root_case == qrs_pkg::CASE_TWO_REAL ||
                 res.root_case == qrs_pkg::CASE_DOUBLE) |-> res.first_imag == '0)
    else $error("real result has imaginary part");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_tail) && $stable(q1))
    else $error("pipeline moved while output was stalled");

endmodule

// File: bench/quadratic_root_solver_top_test.sv
// Testbench for quadratic_root_solver_top: random and directed coefficient sets, predicted roots.
`timescale 1ns / 100ps

module quadratic_root_solver_top_test;

  localparam int CW = 16;
  localparam int LATENCY = 2 * CW + 42;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [CW-1:0] coef_const;
    logic signed [CW-1:0] coef_lin;
    logic signed [CW-1:0] coef_quad;
  } coef_set_t;

  typedef struct packed {
    qrs_pkg::root_case_t root_case;
    logic [31:0] first_real;
    logic [31:0] second_real;
    logic [31:0] first_imag;
    logic        overflow;
  } roots_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [103:0] m_tdata;

  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];
  int        mismatches = 0;
  int        send_idle_pct = 7;
  int        recv_idle_pct = 77;
  bit        hold_send = 0;
  bit        timed_out = 0;
  int        quiet_cycles = 0;

  quadratic_root_solver_top #(.COEF_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // rounded to nearest, ties away from zero, saturated to 32 bits
  function automatic logic [31:0] round_div(input logic signed [63:0] num,
                                            input logic signed [63:0] den,
                                            inout logic ovf);
    logic [63:0] un, ud, q;
    logic        neg;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un + ud / 2) / ud;
    neg = (num < 0) != (den < 0);
    if (!neg && q > 64'h7FFF_FFFF) begin
      ovf = 1;
      return 32'h7FFF_FFFF;
    end
    if (neg && q > 64'h8000_0000) begin
      ovf = 1;
      return 32'h8000_0000;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic logic [63:0] isqrt(input logic [127:0] x);
    logic [63:0] r, t;
    r = 0;
    for (int k = 56; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (128'(t) * 128'(t) <= x) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(input coef_set_t cs);
    roots_t r;
    logic signed [63:0] a, b, c, two_a, nb, s;
    logic signed [127:0] disc;
    logic [127:0] dmag;
    logic ovf;
    a = cs.coef_quad;
    b = cs.coef_lin;
    c = cs.coef_const;
    r = '{qrs_pkg::CASE_TWO_REAL, 0, 0, 0, 0};
    if (a == 0) begin
      r.root_case = qrs_pkg::CASE_DEGEN;
      return r;
    end
    ovf = 0;
    two_a = 2 * a;
    nb = -b * 65536;
    disc = 128'(b) * 128'(b) - 4 * 128'(a) * 128'(c);
    dmag = disc < 0 ? -disc : disc;
    s = isqrt(dmag << 32);
    if (disc > 0) begin
      r.first_real = round_div(nb + s, two_a, ovf);
      r.second_real = round_div(nb - s, two_a, ovf);
    end else begin
      r.root_case = disc == 0 ? qrs_pkg::CASE_DOUBLE : qrs_pkg::CASE_COMPLEX;
      r.first_real = round_div(nb, two_a, ovf);
      r.second_real = r.first_real;
      if (disc < 0) r.first_imag = round_div(s, two_a, ovf);
    end
    r.overflow = ovf;
    return r;
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 8) - 4);
      1: return 16'h8000 + 16'($urandom_range(0, 2));
      2: return 16'h7FFF - 16'($urandom_range(0, 2));
      3: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_roots.push_back(solve_roots(coef_set_t'(s_tdata)));
      if ((!s_tvalid || s_tready) ) begin
        if (pending_sets.size() != 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata <= pending_sets.pop_front();
          s_tvalid <= 1;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    roots_t exp_r, got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{qrs_pkg::root_case_t'(m_tdata[1:0]), m_tdata[33:2], m_tdata[65:34],
                m_tdata[97:66], m_tdata[98]};
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          exp_r = expected_roots.pop_front();
          if (got != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp case %0d %h %h %h ovf %b, got case %0d %h %h %h ovf %b",
                       exp_r.root_case, exp_r.first_real, exp_r.second_real,
                       exp_r.first_imag, exp_r.overflow, got.root_case, got.first_real,
                       got.second_real, got.first_imag, got.overflow);
          end
        end
      end
      m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) timed_out = 1;
    end
  end

  initial begin
    logic [15:0] ext[6] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0100};
    repeat (3) @(posedge clk);
    rst <= 0;
    // degenerate, double, two real, complex, sign mix, extremes
    pending_sets.push_back('{16'h0100, 16'h0200, 16'h0000});
    pending_sets.push_back('{16'h0100, 16'h0200, 16'h0100});
    pending_sets.push_back('{16'hFF00, 16'h0000, 16'h0100});
    pending_sets.push_back('{16'h0100, 16'h0000, 16'h0100});
    pending_sets.push_back('{16'h0100, 16'h0000, 16'hFF00});
    pending_sets.push_back('{16'h0000, 16'h0000, 16'h0000});
    pending_sets.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    for (int i = 0; i < 18; i++)
      pending_sets.push_back('{ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                               ext[(i % 5) + 1]});
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < 450; i++)
        pending_sets.push_back('{rand_coef(), rand_coef(), rand_coef()});
      while ((pending_sets.size() != 0 || s_tvalid) && !timed_out) @(posedge clk);
      if (phase == 0) begin
        hold_send = 1;
        while (expected_roots.size() != 0 && !timed_out) @(posedge clk);
        hold_send = 0;
        send_idle_pct = 77;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
    while (expected_roots.size() != 0 && !timed_out) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (timed_out) begin
      $display("quadratic_root_solver_top test failed");
    end else if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver_top test passed");
    end else begin
      $display("quadratic_root_solver_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/qrs_pkg.sv
rtl/qrs_disc.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver_top.sv
bench/quadratic_root_solver_top_test.sv
